// ----- rtl/bmh_pkg.sv -----
// ----------------------------------------------------------------------------
// bmh_pkg
// shared types and constants for the byte mixing digest core
// ----------------------------------------------------------------------------
`default_nettype none

package bmh_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = WORD_W / 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_message;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_word;
      logic [1:0]        word_index;
      logic              last_word;
   } rsp_type;

   localparam logic [WORD_W-1:0] SEED_VALUE = 64'd1469598103934665603;
   localparam logic [WORD_W-1:0] MUL_BYTE   = 64'd1099511628211;
   localparam logic [WORD_W-1:0] MUL_FOLD   = 64'hff51afd7ed558ccd;
   localparam logic [WORD_W-1:0] GOLDEN     = 64'h9e3779b97f4a7c15;
   localparam logic [WORD_W-1:0] MUL_EXPAND = 64'hc4ceb9fe1a85ec53;
   localparam int                FOLD_SHIFT   = 33;
   localparam int                EXPAND_SHIFT = 29;
   localparam logic [1:0]        LAST_INDEX   = 2'd3;

   // golden ratio times 1, 9, 17, 25, modulo 2^64
   localparam logic [3:0][WORD_W-1:0] GOLDEN_TERM = {
      64'(GOLDEN * 64'd25),
      64'(GOLDEN * 64'd17),
      64'(GOLDEN * 64'd9),
      64'(GOLDEN * 64'd1)
   };

endpackage

`default_nettype wire

// ----- rtl/bmh_mul64.sv -----
// ----------------------------------------------------------------------------
// bmh_mul64
// iterative 64 x 64 multiplier, low 64 bits, one 32 x 32 product per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_mul64 (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [bmh_pkg::WORD_W-1:0] op_a,
   input  wire logic [bmh_pkg::WORD_W-1:0] op_b,
   output logic                           done,
   output logic [bmh_pkg::WORD_W-1:0]     product
);
   import bmh_pkg::*;

   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] b_ff, b_in;
   logic [WORD_W-1:0] pp_ff, pp_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [1:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [HALF_W-1:0] mul_x;
   logic [HALF_W-1:0] mul_y;
   logic [WORD_W-1:0] pp_shift;

   assign pp_shift = {pp_ff[HALF_W-1:0], {HALF_W{1'b0}}};

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      mul_x   = a_ff[HALF_W-1:0];
      mul_y   = b_ff[HALF_W-1:0];
      unique case (step_ff)
         2'd0: begin
            mul_x = a_ff[HALF_W-1:0];
            mul_y = b_ff[HALF_W-1:0];
         end
         2'd1: begin
            mul_x = a_ff[HALF_W-1:0];
            mul_y = b_ff[WORD_W-1:HALF_W];
         end
         2'd2: begin
            mul_x = a_ff[WORD_W-1:HALF_W];
            mul_y = b_ff[HALF_W-1:0];
         end
         default: begin
            mul_x = a_ff[WORD_W-1:HALF_W];
            mul_y = b_ff[HALF_W-1:0];
         end
      endcase
      pp_in = WORD_W'(mul_x) * WORD_W'(mul_y);
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         unique case (step_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = pp_ff;
            2'd2: acc_in = acc_ff + pp_shift;
            default: begin
               acc_in  = acc_ff + pp_shift;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
      if (reset) begin
         step_ff <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ----- rtl/byte_mix_hash_256_core.sv -----
// ----------------------------------------------------------------------------
// byte_mix_hash_256_core
// byte-serial 256-bit mixing digest, four 64-bit words per message
// ----------------------------------------------------------------------------
// One message byte is taken per request transaction; the core is not ready
// again until that byte is absorbed. A byte runs two dependent 64-bit
// multiplies through a single iterative multiplier that forms one 32 x 32
// partial product per cycle. On the last byte four digest words follow, one
// response transaction each; each of the first three words also runs one
// multiply. An empty message returns four zero words right away and
// restarts the state.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_mix_hash_256_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bmh_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bmh_pkg::rsp_type      rsp_data
);
   import bmh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_BYTE,
      ST_MUL_FOLD,
      ST_WORD,
      ST_MUL_EXP,
      ST_ZERO
   } state_type;

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] count_ff, count_in;
   logic              last_ff, last_in;
   logic [1:0]        idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              mul_start;
   logic [WORD_W-1:0] mul_a;
   logic [WORD_W-1:0] mul_b;
   logic              mul_done;
   logic [WORD_W-1:0] mul_prod;
   logic [WORD_W-1:0] word_sum;
   logic              out_free;

   bmh_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign word_sum = acc_ff + GOLDEN_TERM[idx_ff] + {count_ff[WORD_W-2:0], 1'b0};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      mul_a        = acc_ff;
      mul_b        = MUL_BYTE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.empty_message) begin
                  acc_in   = SEED_VALUE;
                  count_in = '0;
                  idx_in   = 2'd0;
                  state_in = ST_ZERO;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = acc_ff ^ {{(WORD_W-8){1'b0}}, req_data.data_byte};
                  mul_b     = MUL_BYTE;
                  count_in  = count_ff + 64'd1;
                  last_in   = req_data.last_byte;
                  state_in  = ST_MUL_BYTE;
               end
            end
         end
         ST_MUL_BYTE: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = mul_prod ^ (mul_prod >> FOLD_SHIFT);
               mul_b     = MUL_FOLD;
               state_in  = ST_MUL_FOLD;
            end
         end
         ST_MUL_FOLD: begin
            if (mul_done) begin
               acc_in = mul_prod;
               idx_in = 2'd0;
               if (last_ff) begin
                  state_in = ST_WORD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WORD: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.digest_word = word_sum;
               rsp_data_in.word_index  = idx_ff;
               rsp_data_in.last_word   = (idx_ff == LAST_INDEX);
               if (idx_ff == LAST_INDEX) begin
                  acc_in   = SEED_VALUE;
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = acc_ff ^ (word_sum >> EXPAND_SHIFT);
                  mul_b     = MUL_EXPAND;
                  state_in  = ST_MUL_EXP;
               end
            end
         end
         ST_MUL_EXP: begin
            if (mul_done) begin
               acc_in   = mul_prod;
               idx_in   = idx_ff + 2'd1;
               state_in = ST_WORD;
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.digest_word = '0;
               rsp_data_in.word_index  = idx_ff;
               rsp_data_in.last_word   = (idx_ff == LAST_INDEX);
               idx_in                  = idx_ff + 2'd1;
               if (idx_ff == LAST_INDEX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= SEED_VALUE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // assertions

   a_last_word_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.last_word == (rsp_data_ff.word_index == LAST_INDEX)))
      else $error("last_word does not match word_index");

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_BYTE || state_ff == ST_MUL_FOLD ||
                    state_ff == ST_MUL_EXP))
      else $error("multiplier finished outside a multiply state");

   a_empty_restart: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.empty_message) |=>
         (acc_ff == SEED_VALUE && count_ff == '0 && state_ff == ST_ZERO))
      else $error("empty message did not restart the state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("pending response transaction dropped");

endmodule

`default_nettype wire
